>>> hw/rtl/quadrature_detent_decoder_assert.svh
// Assertion macros shared by the decoder's checker.
// Depends on nothing; included by files that hold concurrent assertions.
`ifndef QUADRATURE_DETENT_DECODER_ASSERT_SVH
`define QUADRATURE_DETENT_DECODER_ASSERT_SVH

// Same-cycle implication, disabled while reset is high.
`define QDD_ASSERT_IMPL(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> cons) \
      else $error(msg);

// Next-cycle implication, disabled while reset is high.
`define QDD_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> cons) \
      else $error(msg);

`endif

>>> hw/rtl/qdd_pkg.sv
// Types and constants for the quadrature detent decoder.
// No dependencies; imported by the top level.
package qdd_pkg;

   localparam int PIN_W      = 2;
   localparam int COUNT_W    = 32;
   localparam int DELTA_W    = 30;
   localparam int REQ_DATA_W = 40;
   localparam int RSP_DATA_W = 96;

   typedef enum logic [1:0] {
      CMD_SAMPLE    = 2'd0,
      CMD_POLL      = 2'd1,
      CMD_SET_TOTAL = 2'd2,
      CMD_LOAD_PINS = 2'd3
   } cmd_type;

   typedef logic signed [1:0] dir_type;

   // Step per transition, indexed by {previous pair, current pair}.
   localparam dir_type STEP_LUT [16] = '{
       2'sd0, -2'sd1,  2'sd1,  2'sd0,
       2'sd1,  2'sd0,  2'sd0, -2'sd1,
      -2'sd1,  2'sd0,  2'sd0,  2'sd1,
       2'sd0,  2'sd1, -2'sd1,  2'sd0
   };

   typedef struct packed {
      cmd_type                    command;
      logic [PIN_W-1:0]           pins;       // {pin_a, pin_b}
      logic signed [COUNT_W-1:0]  new_total;
   } req_type;

endpackage

>>> hw/rtl/quadrature_detent_decoder.sv
// Quadrature detent decoder (x4), top level.
// Depends on qdd_pkg.
//
// Usage:
//   req channel: one item per command. tuser carries the command (sample pins,
//   poll detents, set total, load pins). tdata carries pin_a, pin_b and
//   new_total.
//   rsp channel: exactly one item per request item, in order, carrying the
//   latest detent delta, the running total and the pending transition count
//   as they stand after that request.
// Path: a request accept passes the input register, then the result register,
//   to rsp_tvalid; between the two registers sit a table lookup or a divide by
//   4 (bias add and shift), followed by one 32-bit add.
// Throughput: one item per cycle, sustained, while rsp_tready stays high.
// Stall: when rsp_tready is low the result register holds its item; one more
//   item is taken into the input register and then req_tready drops until the
//   result is taken.
// Reset: synchronous, active high; both stages empty, pin pair, transition
//   count, delta and total all zero.
module quadrature_detent_decoder
   import qdd_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   // request channel
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [REQ_DATA_W-1:0] req_tdata,   // pin_a, pin_b, new_total[31:0], 6'b0
   input  logic [1:0]            req_tuser,   // command
   // result channel
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [RSP_DATA_W-1:0] rsp_tdata    // detent_delta[29:0], total_value[31:0],
                                              // pending_ticks[31:0], 2'b0
);

   // input stage
   logic    s1_valid_ff;
   req_type s1_req_ff;

   // decoder state
   logic [PIN_W-1:0]          prev_pins_ff,   prev_pins_in;
   logic signed [COUNT_W-1:0] count_ff,       count_in;
   logic signed [DELTA_W-1:0] delta_ff,       delta_in;
   logic signed [COUNT_W-1:0] total_ff,       total_in;

   // result stage
   logic                  rsp_valid_ff;
   logic [RSP_DATA_W-1:0] rsp_data_ff;

   logic out_free;
   logic advance;

   dir_type                   dir_step;
   logic signed [COUNT_W-1:0] count_bias;
   logic signed [COUNT_W-1:0] quot;
   logic signed [COUNT_W-1:0] rem;

   // handshake: the result register frees itself when taken
   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign advance    = s1_valid_ff && out_free;
   assign req_tready = !s1_valid_ff || out_free;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (req_tready) begin
         s1_valid_ff <= req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         s1_req_ff.command   <= cmd_type'(req_tuser);
         s1_req_ff.pins      <= {req_tdata[0], req_tdata[1]};
         s1_req_ff.new_total <= req_tdata[33:2];
      end
   end

   // count / 4 truncated toward zero: bias negatives by 3 before the shift.
   // For |count| < 4 this gives quot 0 and rem = count, so no range check.
   assign count_bias = count_ff + 32'sd3;
   assign quot       = count_ff[COUNT_W-1] ? (count_bias >>> 2) : (count_ff >>> 2);
   assign rem        = count_ff - (quot <<< 2);
   // unchanged pins hit a zero entry, so no separate compare
   assign dir_step   = STEP_LUT[{prev_pins_ff, s1_req_ff.pins}];

   always_comb begin
      prev_pins_in = prev_pins_ff;
      count_in     = count_ff;
      delta_in     = delta_ff;
      total_in     = total_ff;
      case (s1_req_ff.command)
         CMD_SAMPLE: begin
            count_in     = count_ff + COUNT_W'(dir_step);
            prev_pins_in = s1_req_ff.pins;
         end
         CMD_POLL: begin
            count_in = rem;
            delta_in = quot[DELTA_W-1:0];
            total_in = total_ff + quot;   // quot always fits in 30 bits
         end
         CMD_SET_TOTAL: begin
            total_in = s1_req_ff.new_total;
            delta_in = '0;
         end
         CMD_LOAD_PINS: begin
            prev_pins_in = s1_req_ff.pins;
         end
         default: begin
            prev_pins_in = prev_pins_ff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prev_pins_ff <= '0;
         count_ff     <= '0;
         delta_ff     <= '0;
         total_ff     <= '0;
      end else if (advance) begin
         prev_pins_ff <= prev_pins_in;
         count_ff     <= count_in;
         delta_ff     <= delta_in;
         total_ff     <= total_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (out_free) begin
         rsp_valid_ff <= s1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_data_ff <= {2'b00, count_in, total_in, delta_in};
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

endmodule

>>> hw/rtl/qdd_checker.sv
// Port-level checker for the quadrature detent decoder, with its bind.
// Depends on qdd_pkg and quadrature_detent_decoder_assert.svh.
`include "quadrature_detent_decoder_assert.svh"

module qdd_checker
   import qdd_pkg::*;
(
   input logic                  clock,
   input logic                  reset,
   input logic                  req_tvalid,
   input logic                  req_tready,
   input logic [REQ_DATA_W-1:0] req_tdata,
   input logic [1:0]            req_tuser,
   input logic                  rsp_tvalid,
   input logic                  rsp_tready,
   input logic [RSP_DATA_W-1:0] rsp_tdata
);

   // an accepted item passes the input and then the result register
   `QDD_ASSERT_IMPL(a_accept_to_result, clock, reset, req_tvalid && req_tready, ##2 rsp_tvalid, "accepted item did not reach the result stage")

   // with an empty result stage the block must take input
   `QDD_ASSERT_IMPL(a_ready_when_empty, clock, reset, !rsp_tvalid, req_tready, "request stalled with no result pending")

   // stalled result holds
   `QDD_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_tvalid && !rsp_tready, rsp_tvalid && $stable(rsp_tdata), "stalled result changed")

endmodule

bind quadrature_detent_decoder qdd_checker u_qdd_checker (.*);

>>> tb/sv/qdd_checker.sv
`timescale 1ns / 100ps
// Checker for quadrature_detent_decoder: watches both streams, predicts each result item
// from its own copy of the decoder state and compares it field by field. Depends on qdd_pkg.
module qdd_tb_checker
   import qdd_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   input  logic                  req_tready,
   input  logic [REQ_DATA_W-1:0] req_tdata,   // pin_a, pin_b, new_total[31:0], 6'b0
   input  logic [1:0]            req_tuser,   // command
   input  logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   input  logic [RSP_DATA_W-1:0] rsp_tdata,   // detent_delta, total_value, pending_ticks, 2'b0
   output int                    error_count,
   output int                    owed_count
);

   typedef struct packed {
      logic signed [DELTA_W-1:0] delta;
      logic signed [COUNT_W-1:0] total;
      logic signed [COUNT_W-1:0] ticks;
   } readout_type;

   readout_type               owed_readouts[$];
   logic [PIN_W-1:0]          pin_pair;
   logic signed [COUNT_W-1:0] tick_count;
   logic signed [COUNT_W-1:0] detent_total;
   logic signed [DELTA_W-1:0] detent_delta;

   // x4 decode: +1 / -1 for a one-pin step, 0 for no change or a double jump
   function automatic int turn_step(input logic [1:0] prev, input logic [1:0] cur);
      case ({prev, cur})
         4'b0010, 4'b0100, 4'b1011, 4'b1101: return 1;
         4'b0001, 4'b0111, 4'b1000, 4'b1110: return -1;
         default: return 0;
      endcase
   endfunction

   task automatic advance_decoder(input cmd_type cmd, input logic [1:0] pins,
                                  input logic signed [COUNT_W-1:0] load);
      logic signed [COUNT_W-1:0] whole;
      readout_type               r;
      case (cmd)
         CMD_SAMPLE: begin
            if (pins != pin_pair) begin
               tick_count = tick_count + turn_step(pin_pair, pins);
               pin_pair   = pins;
            end
         end
         CMD_POLL: begin
            whole = '0;
            if (tick_count >= 4 || tick_count <= -4) begin
               whole      = tick_count / 4;   // truncates toward zero
               tick_count = tick_count % 4;   // remainder keeps the count's sign
            end
            detent_delta = whole[DELTA_W-1:0];
            detent_total = detent_total + detent_delta;
         end
         CMD_SET_TOTAL: begin
            detent_total = load;
            detent_delta = '0;
         end
         default: pin_pair = pins;   // load pins, no counting
      endcase
      r.delta = detent_delta;
      r.total = detent_total;
      r.ticks = tick_count;
      owed_readouts.push_back(r);
   endtask

   task automatic check_readout(input logic [RSP_DATA_W-1:0] data);
      readout_type want;
      readout_type got;
      got.delta = data[29:0];
      got.total = data[61:30];
      got.ticks = data[93:62];
      if (owed_readouts.size() == 0) begin
         error_count++;
         $display("%0t: result item with none expected: delta %0d total %0d ticks %0d",
                  $time, got.delta, got.total, got.ticks);
      end else begin
         want = owed_readouts.pop_front();
         if (got.delta !== want.delta) begin
            error_count++;
            $display("%0t: detent_delta expected %0d actual %0d", $time, want.delta, got.delta);
         end
         if (got.total !== want.total) begin
            error_count++;
            $display("%0t: total_value expected %0d actual %0d", $time, want.total, got.total);
         end
         if (got.ticks !== want.ticks) begin
            error_count++;
            $display("%0t: pending_ticks expected %0d actual %0d", $time, want.ticks, got.ticks);
         end
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         owed_readouts.delete();
         pin_pair     = '0;
         tick_count   = '0;
         detent_total = '0;
         detent_delta = '0;
      end else begin
         if (rsp_tvalid && rsp_tready)
            check_readout(rsp_tdata);
         if (req_tvalid && req_tready)
            advance_decoder(cmd_type'(req_tuser), req_tdata[1:0] == 2'b01 ? 2'b10 :
                            req_tdata[1:0] == 2'b10 ? 2'b01 : req_tdata[1:0],
                            req_tdata[33:2]);
      end
      owed_count = owed_readouts.size();
   end

endmodule

>>> tb/sv/tb.sv
`timescale 1ns / 100ps
// Top of the quadrature_detent_decoder testbench: clock, reset, request stimulus and
// result back-pressure, with the verdict. Depends on qdd_pkg and qdd_tb_checker.
module tb;
   import qdd_pkg::*;

   localparam int CYCLE_LIMIT  = 300000;
   localparam int RANDOM_ITEMS = 1150;

   logic                  clock      = 1'b0;
   logic                  reset      = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata  = '0;   // pin_a, pin_b, new_total[31:0], 6'b0
   logic [1:0]            req_tuser  = CMD_SAMPLE;   // command
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;   // detent_delta, total_value, pending_ticks, 2'b0

   int   error_count;
   int   owed_count;
   int   cycle_count = 0;
   bit   calm = 1'b0;          // set during the stretch without idling
   logic [1:0] shaft_pins = 2'b00;   // {pin_a, pin_b} last sent by sample/load-pins

   quadrature_detent_decoder DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   qdd_tb_checker u_checker (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .error_count (error_count),
      .owed_count  (owed_count)
   );

   always #5 clock = ~clock;

   // hang guard
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("Test completed with failures");
         $finish;
      end
   end

   // result side: drops ready at random, one chance in ten, never in the calm stretch
   always @(negedge clock)
      rsp_tready <= calm || ($urandom_range(99) >= 10);

   // One request item; unused fields carry what the caller passes, mostly random junk.
   task automatic send_item(input cmd_type cmd, input logic [1:0] pins,
                            input logic [31:0] load);
      @(negedge clock);
      while (!calm && $urandom_range(99) < 10) begin
         req_tvalid <= 1'b0;
         @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= cmd;
      req_tdata  <= {6'b0, load, pins[0], pins[1]};   // pin_a lowest, then pin_b
      do @(posedge clock); while (!req_tready);
      if (cmd == CMD_SAMPLE || cmd == CMD_LOAD_PINS)
         shaft_pins = pins;
   endtask

   // one legal quadrature step; up = count +1
   task automatic turn(input bit up);
      logic [1:0] nxt;
      case (shaft_pins)
         2'b00:   nxt = up ? 2'b10 : 2'b01;
         2'b10:   nxt = up ? 2'b11 : 2'b00;
         2'b11:   nxt = up ? 2'b01 : 2'b10;
         default: nxt = up ? 2'b00 : 2'b11;
      endcase
      send_item(CMD_SAMPLE, nxt, $urandom);
   endtask

   initial begin
      int  sent;
      int  run_len;
      int  pick;
      bit  up;
      bit  paused;

      repeat (11) @(posedge clock);
      @(negedge clock) reset <= 1'b0;

      // directed part
      send_item(CMD_SAMPLE, 2'b00, 32'hFFFF_FFFF);    // unchanged pins
      repeat (4) turn(1'b1);
      send_item(CMD_POLL, 2'b11, 32'hFFFF_FFFF);      // +1 detent
      repeat (6) turn(1'b0);
      send_item(CMD_POLL, 2'b01, 32'h0);              // -1 detent, -2 left over
      send_item(CMD_SAMPLE, ~shaft_pins, $urandom);   // double jump, no count
      send_item(CMD_LOAD_PINS, 2'b10, $urandom);
      send_item(CMD_SET_TOTAL, 2'b11, 32'h7FFF_FFFF);
      repeat (6) turn(1'b1);
      send_item(CMD_POLL, 2'b00, $urandom);           // total wraps to min
      send_item(CMD_POLL, 2'b10, $urandom);           // under four ticks, zero delta
      send_item(CMD_SET_TOTAL, 2'b01, 32'h8000_0000);
      repeat (4) turn(1'b0);
      send_item(CMD_POLL, 2'b11, $urandom);           // total wraps to max

      // random part: mostly legal rotation with polls, plus noise
      sent   = 0;
      paused = 1'b0;
      while (sent < RANDOM_ITEMS) begin
         calm = (sent >= 400 && sent < 650);
         if (!paused && sent >= 700) begin
            // hold off until every result has drained
            paused = 1'b1;
            @(negedge clock) req_tvalid <= 1'b0;
            while (owed_count != 0) @(posedge clock);
         end
         pick = $urandom_range(99);
         if (pick < 55) begin
            run_len = ($urandom_range(9) == 0) ? $urandom_range(60, 200)
                                                : $urandom_range(1, 30);
            up = 1'($urandom_range(1));
            repeat (run_len) begin
               turn($urandom_range(9) == 0 ? !up : up);
               sent++;
            end
         end else begin
            if (pick < 75)
               send_item(CMD_POLL, 2'($urandom_range(3)), $urandom);
            else if (pick < 82)
               send_item(CMD_SET_TOTAL, 2'($urandom_range(3)), $urandom);
            else if (pick < 87)
               send_item(CMD_LOAD_PINS, 2'($urandom_range(3)), $urandom);
            else
               send_item(CMD_SAMPLE, 2'($urandom_range(3)), $urandom);   // noise
            sent++;
         end
      end
      calm = 1'b0;
      @(negedge clock) req_tvalid <= 1'b0;

      while (owed_count != 0) @(posedge clock);
      repeat (8) @(posedge clock);

      if (error_count == 0 && owed_count == 0)
         $display("Test completed successfully");
      else
         $display("Test completed with failures");
      $finish;
   end

endmodule

>>> sim.f
+incdir+hw/rtl
hw/rtl/qdd_pkg.sv
hw/rtl/quadrature_detent_decoder.sv
hw/rtl/qdd_checker.sv
tb/sv/qdd_checker.sv
tb/sv/tb.sv
